@@ rtl/pfd_pkg.sv @@
// ----------------------------------------------------------------------------
// pfd_pkg: shared types and constants of the flood detector
// Key and write-command structs, register indexes, outcome codes, states.
// ----------------------------------------------------------------------------
package pfd_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_TRACKED_ENTRIES = 2'd0;
	localparam logic [1:0] REG_FLOOD_AFTER     = 2'd1;
	localparam logic [1:0] REG_FLOOD_RATE      = 2'd2;

	// outcome codes
	localparam logic [1:0] OUT_NOT_CHECKED = 2'd0;
	localparam logic [1:0] OUT_DISABLED    = 2'd1;
	localparam logic [1:0] OUT_NO_FLOOD    = 2'd2;
	localparam logic [1:0] OUT_FLOOD       = 2'd3;

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
	localparam logic [15:0] FLOOD_MAX = 16'hFFFF;

	// lookup key of one message
	typedef struct packed {
		logic [7:0]  server;
		logic [31:0] sender;
		logic        has_chan;
		logic [31:0] chan;
		logic [1:0]  kind;
	} key_t;

	// write command broadcast to the cells
	typedef struct packed {
		logic        clear;   // drop every slot
		logic        insert;  // selected cell takes the key
		logic        update;  // selected cell takes count/start/flood
		logic [31:0] count;
		logic [31:0] start;
		logic [15:0] flood;
	} cell_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_HIT,
		ST_RATE,
		ST_DEC,
		ST_SCAN,
		ST_OUT
	} state_t;

endpackage

@@ rtl/pfd_cell.sv @@
// ----------------------------------------------------------------------------
// pfd_cell: one table slot
// Holds a key, message count, start time and flood count; compares the key
// and passes the first-match flag on to the next cell.
// ----------------------------------------------------------------------------
module pfd_cell
	import pfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        enable,     // slot lies within the tracked range
	input  key_t        key,
	input  logic        hit_in,     // an earlier cell matched
	output logic        hit_out,
	output logic        sel,        // this cell is the first match
	input  logic        wr_sel,     // write command targets this cell
	input  cell_wr_t    wr,
	output logic        flood_zero,
	output logic [31:0] count,
	output logic [31:0] start,
	output logic [15:0] flood
);

	logic        used_q;
	key_t        key_q;
	logic [31:0] count_q;
	logic [31:0] start_q;
	logic [15:0] flood_q;
	logic        match;

	// key compare, channel only when present
	always_comb begin
		match = enable && used_q && key_q.kind == key.kind && key_q.server == key.server
			&& key_q.sender == key.sender && key_q.has_chan == key.has_chan
			&& (!key.has_chan || key_q.chan == key.chan);
	end

	assign sel        = match && !hit_in;
	assign hit_out    = hit_in || match;
	assign flood_zero = (flood_q == '0);
	assign count      = count_q;
	assign start      = start_q;
	assign flood      = flood_q;

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			key_q   <= '0;
			count_q <= '0;
			start_q <= '0;
			flood_q <= '0;
		end else if (wr.clear) begin
			used_q  <= 1'b0;
			flood_q <= '0;
		end else if (wr_sel) begin
			if (wr.insert) begin
				used_q <= 1'b1;
				key_q  <= key;
			end
			if (wr.update) begin
				count_q <= wr.count;
				start_q <= wr.start;
				flood_q <= wr.flood;
			end
		end
	end

endmodule

@@ rtl/per_source_flood_detector_core.sv @@
// ----------------------------------------------------------------------------
// per_source_flood_detector_core: per-source message flood detector
// Row of slot cells searched by key; misses take a slot by round-robin scan,
// hits update the count and test the message rate.
// ----------------------------------------------------------------------------
//  channel  | dir | words                      | handshake
//  s_axis   | in  | message event              | tvalid/tready
//  m_axis   | out | outcome, slot, count       | tvalid/tready
//  cfg      | in  | register write             | cfg_we, no wait
//
// Unknown server or disabled checking: accept, then output.
// Hit: accept, lookup, read, multiply, decide, output.
// Miss: accept, lookup, scan of 1..min(tracked_entries, MAX_SLOTS) slots, output.
// One word at a time; a new word is taken once the previous has reached the
// output register, which may still be waiting on m_axis_tready.
// Reset clears the table at once; writing tracked_entries clears it too.
// ----------------------------------------------------------------------------
module per_source_flood_detector_core
	import pfd_pkg::*;
#(
	parameter int MAX_SLOTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [0] server_known, [8:1] server_id, [40:9] sender_id, [41] on_channel,
	// [73:42] channel_id, [105:74] now_seconds, [111:106] zero
	input  logic [111:0] s_axis_tdata,
	// [1:0] kind
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [1:0] outcome, [5:2] slot_index, [37:6] repeat_count, [39:38] zero
	output logic [39:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [15:0]  cfg_wdata
);

	localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int NW = $clog2(MAX_SLOTS + 1);

	state_t state_q, state_d;

	logic [4:0]  tracked_q;
	logic [15:0] after_q;
	logic [15:0] rate_q;
	logic [IW-1:0] ptr_q, p_q, start_ptr_q, hit_idx_q;
	key_t        key_q;
	logic [31:0] now_q;
	logic [MAX_SLOTS-1:0] sel_q;
	logic [31:0] cnt_q, diff_q;
	logic [15:0] fc_q;
	logic [47:0] prod_q;
	logic [1:0]  res_outcome_q;
	logic [IW-1:0] res_idx_q;
	logic [31:0] res_count_q;
	logic        m_valid_q;
	logic [39:0] m_data_q;

	logic [NW-1:0] n;
	logic          in_fire, out_load;
	logic [MAX_SLOTS-1:0] hit_chain, sel_vec, fz_vec;
	logic [31:0]   cell_cnt [MAX_SLOTS];
	logic [31:0]   cell_start [MAX_SLOTS];
	logic [15:0]   cell_fc [MAX_SLOTS];
	logic [31:0]   rd_cnt, rd_start;
	logic [15:0]   rd_fc;
	logic [IW-1:0] sel_idx, p_next, scan_start;
	logic [MAX_SLOTS-1:0] wr_sel;
	cell_wr_t      wr;
	logic          scan_done, flood_now;

	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

	// slots in use, limited to the table size
	assign n = (32'(tracked_q) > MAX_SLOTS) ? NW'(MAX_SLOTS) : NW'(tracked_q);

	// row of slot cells with first-match chain
	for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
		pfd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.enable     (32'(i) < 32'(n)),
			.key        (key_q),
			.hit_in     ((i == 0) ? 1'b0 : hit_chain[(i == 0) ? 0 : i-1]),
			.hit_out    (hit_chain[i]),
			.sel        (sel_vec[i]),
			.wr_sel     (wr_sel[i]),
			.wr         (wr),
			.flood_zero (fz_vec[i]),
			.count      (cell_cnt[i]),
			.start      (cell_start[i]),
			.flood      (cell_fc[i])
		);
	end

	// encode the match and read the selected slot
	always_comb begin
		sel_idx  = '0;
		rd_cnt   = '0;
		rd_start = '0;
		rd_fc    = '0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if (sel_vec[i]) sel_idx = IW'(i);
			rd_cnt   = rd_cnt   | (cell_cnt[i]   & {32{sel_q[i]}});
			rd_start = rd_start | (cell_start[i] & {32{sel_q[i]}});
			rd_fc    = rd_fc    | (cell_fc[i]    & {16{sel_q[i]}});
		end
	end

	// round-robin scan step
	assign scan_start = (32'(ptr_q) >= 32'(n)) ? '0 : ptr_q;
	assign p_next     = (32'(p_q) + 32'd1 == 32'(n)) ? '0 : IW'(32'(p_q) + 32'd1);
	assign scan_done  = fz_vec[p_next] || (p_next == start_ptr_q);
	assign flood_now  = (diff_q == '0) || ({16'd0, cnt_q} >= prod_q);

	// cell write command
	always_comb begin
		wr        = '0;
		wr_sel    = '0;
		wr.clear  = cfg_we && (cfg_addr == REG_TRACKED_ENTRIES);
		wr.count  = cnt_q;
		wr.start  = diff_q;
		wr.flood  = fc_q;
		if (state_q == ST_SCAN && scan_done) begin
			wr.insert       = 1'b1;
			wr.update       = 1'b1;
			wr.count        = 32'd1;
			wr.start        = now_q;
			wr.flood        = rd_fc;
			wr_sel[p_next]  = 1'b1;
			wr.flood        = cell_fc[p_next];
		end else if (state_q == ST_DEC) begin
			wr.update          = 1'b1;
			wr_sel[hit_idx_q]  = 1'b1;
			wr.count           = cnt_q;
			wr.start           = cell_start[hit_idx_q];
			wr.flood           = fc_q;
			if (cnt_q >= {16'd0, after_q}) begin
				if (flood_now) begin
					wr.flood = (fc_q == FLOOD_MAX) ? fc_q : fc_q + 16'd1;
				end else begin
					wr.count = 32'd1;
					wr.start = now_q;
					wr.flood = '0;
				end
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) state_d = (s_axis_tdata[0] && tracked_q != '0) ? ST_LOOK : ST_OUT;
			ST_LOOK: state_d = (hit_chain[MAX_SLOTS-1]) ? ST_HIT : ST_SCAN;
			ST_HIT:  state_d = ST_RATE;
			ST_RATE: state_d = ST_DEC;
			ST_DEC:  state_d = ST_OUT;
			ST_SCAN: if (scan_done) state_d = ST_OUT;
			ST_OUT:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// configuration registers and insert pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q <= 5'd3;
			after_q   <= 16'd3;
			rate_q    <= 16'd3;
			ptr_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_TRACKED_ENTRIES: begin
						tracked_q <= cfg_wdata[4:0];
						ptr_q     <= '0;
					end
					REG_FLOOD_AFTER: after_q <= cfg_wdata;
					REG_FLOOD_RATE:  rate_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == ST_SCAN && scan_done) ptr_q <= p_next;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q.server  <= s_axis_tdata[8:1];
			key_q.sender  <= s_axis_tdata[40:9];
			key_q.has_chan <= s_axis_tdata[41];
			key_q.chan    <= s_axis_tdata[41] ? s_axis_tdata[73:42] : 32'd0;
			key_q.kind    <= s_axis_tuser;
			now_q         <= s_axis_tdata[105:74];
			res_outcome_q <= s_axis_tdata[0] ? OUT_DISABLED : OUT_NOT_CHECKED;
			res_idx_q     <= '0;
			res_count_q   <= '0;
		end
		unique case (state_q)
			ST_LOOK: begin
				sel_q       <= sel_vec;
				hit_idx_q   <= sel_idx;
				start_ptr_q <= scan_start;
				p_q         <= scan_start;
			end
			ST_HIT: begin
				cnt_q  <= (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 32'd1;
				diff_q <= now_q - rd_start;
				fc_q   <= rd_fc;
			end
			ST_RATE: prod_q <= {32'd0, rate_q} * {16'd0, diff_q};
			ST_DEC: begin
				res_idx_q     <= hit_idx_q;
				res_outcome_q <= (cnt_q >= {16'd0, after_q} && flood_now) ?
					OUT_FLOOD : OUT_NO_FLOOD;
				res_count_q   <= (cnt_q >= {16'd0, after_q} && !flood_now) ?
					32'd1 : cnt_q;
			end
			ST_SCAN: begin
				p_q <= p_next;
				if (scan_done) begin
					res_outcome_q <= OUT_NO_FLOOD;
					res_idx_q     <= p_next;
					res_count_q   <= 32'd1;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
				m_data_q  <= {2'b00, res_count_q, 4'(res_idx_q), res_outcome_q};
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel_vec)) else $error("several cells claim the key");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> 32'(p_q) < 32'(n)) else $error("scan pointer out of range");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_axis_tready) else $error("word taken while busy");
	a_unknown_direct: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !s_axis_tdata[0] |=> state_q == ST_OUT) else $error("unknown server checked");
`endif

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the per-source flood detector
// Drives message words through a directed table and then random traffic
// around a small pool of keys, predicts result words from a slot-table model
// or a typed-in row, and checks each output field under varied flow control.
// ----------------------------------------------------------------------------
module tb_top;
	import pfd_pkg::*;

	localparam int NSLOTS = 16;
	localparam int LIMIT  = 400000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [39:0]  m_axis_tdata;
	logic         cfg_we;
	logic [1:0]   cfg_addr;
	logic [15:0]  cfg_wdata;

	typedef struct packed {
		logic        known;
		logic [7:0]  server;
		logic [31:0] sender;
		logic        on_chan;
		logic [31:0] chan;
		logic [1:0]  kind;
		logic [31:0] now;
	} msg_t;

	typedef struct packed {
		logic [1:0]  outcome;
		logic [3:0]  slot;
		logic [31:0] count;
	} verdict_t;

	// directed row; check_typed marks rows whose result is typed in
	typedef struct packed {
		msg_t     m;
		logic     check_typed;
		verdict_t v;
	} row_t;

	per_source_flood_detector_core #(.MAX_SLOTS(NSLOTS)) DUT (.*);

	// predictor state
	logic [4:0]  trk;
	logic [15:0] after_th, rate_th;
	logic        t_used   [NSLOTS];
	logic [7:0]  t_server [NSLOTS];
	logic [31:0] t_sender [NSLOTS];
	logic        t_hasch  [NSLOTS];
	logic [31:0] t_chan   [NSLOTS];
	logic [1:0]  t_kind   [NSLOTS];
	logic [31:0] t_count  [NSLOTS];
	logic [31:0] t_start  [NSLOTS];
	logic [15:0] t_flood  [NSLOTS];
	int          ins_ptr;

	verdict_t pending_verdicts[$];
	int  errors, words_in, words_out, floods, cycles;
	int  send_idle_pct, recv_stall_pct;
	logic [31:0] clock_s;

	function automatic void clear_slots();
		for (int i = 0; i < NSLOTS; i++) begin
			t_used[i] = 0; t_server[i] = 0; t_sender[i] = 0; t_hasch[i] = 0;
			t_chan[i] = 0; t_kind[i] = 0; t_count[i] = 0; t_start[i] = 0;
			t_flood[i] = 0;
		end
		ins_ptr = 0;
	endfunction

	// slot-table rate decision for one message
	function automatic verdict_t judge_message(msg_t m);
		verdict_t v;
		int n, i, p, st;
		logic [31:0] diff;
		v = '0;
		if (!m.known) begin
			v.outcome = OUT_NOT_CHECKED;
			return v;
		end
		n = (trk > NSLOTS) ? NSLOTS : trk;
		if (n == 0) begin
			v.outcome = OUT_DISABLED;
			return v;
		end
		for (i = 0; i < n; i++)
			if (t_used[i] && t_kind[i] == m.kind && t_server[i] == m.server &&
			    t_sender[i] == m.sender && t_hasch[i] == m.on_chan &&
			    (!m.on_chan || t_chan[i] == m.chan))
				break;
		if (i == n) begin
			if (ins_ptr >= n) ins_ptr = 0;
			st = ins_ptr;
			p = st;
			do p = (p + 1) % n; while (t_flood[p] != 0 && p != st);
			ins_ptr = p;
			t_used[p] = 1; t_server[p] = m.server; t_sender[p] = m.sender;
			t_hasch[p] = m.on_chan; t_chan[p] = m.on_chan ? m.chan : 0;
			t_kind[p] = m.kind; t_count[p] = 1; t_start[p] = m.now;
			v.outcome = OUT_NO_FLOOD; v.slot = 4'(p); v.count = 1;
			return v;
		end
		if (t_count[i] != COUNT_MAX) t_count[i]++;
		v.outcome = OUT_NO_FLOOD;
		if (t_count[i] >= {16'd0, after_th}) begin
			diff = m.now - t_start[i];
			if (diff == 0 || t_count[i] / diff >= {16'd0, rate_th}) begin
				if (t_flood[i] != FLOOD_MAX) t_flood[i]++;
				v.outcome = OUT_FLOOD;
			end else begin
				t_flood[i] = 0; t_count[i] = 1; t_start[i] = m.now;
			end
		end
		v.slot = 4'(i); v.count = t_count[i];
		return v;
	endfunction

	// clock, cycle limit
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver stalls
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// result checking
	always @(posedge clk) begin
		verdict_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.outcome = m_axis_tdata[1:0];
			got.slot    = m_axis_tdata[5:2];
			got.count   = m_axis_tdata[37:6];
			words_out++;
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result word %h", m_axis_tdata);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (got.outcome == OUT_FLOOD) floods++;
				if (got.outcome !== want.outcome) begin
					$error("outcome exp %0d got %0d", want.outcome, got.outcome);
					errors++;
				end
				if (got.slot !== want.slot) begin
					$error("slot_index exp %0d got %0d", want.slot, got.slot);
					errors++;
				end
				if (got.count !== want.count) begin
					$error("repeat_count exp %0d got %0d", want.count, got.count);
					errors++;
				end
				if (m_axis_tdata[39:38] !== 2'b00) begin
					$error("tdata pad exp 0 got %b", m_axis_tdata[39:38]);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			REG_TRACKED_ENTRIES: begin trk = val[4:0]; clear_slots(); end
			REG_FLOOD_AFTER:     after_th = val;
			REG_FLOOD_RATE:      rate_th = val;
			default: ;
		endcase
	endtask

	// wait until every result word is back
	task automatic drain();
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// present one word, predict on acceptance
	task automatic send_message(msg_t m, logic typed, verdict_t tv);
		verdict_t v;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		s_axis_tvalid <= 1;
		s_axis_tdata  <= {6'd0, m.now, m.chan, m.on_chan, m.sender, m.server, m.known};
		s_axis_tuser  <= m.kind;
		do @(posedge clk); while (!s_axis_tready);
		v = judge_message(m);
		pending_verdicts.push_back(typed ? tv : v);
		words_in++;
		@(negedge clk);
		s_axis_tvalid <= 0;
	endtask

	function automatic msg_t random_message(int pool);
		msg_t m;
		m.known   = ($urandom_range(19) != 0);
		m.server  = (pool > 0) ? 8'($urandom_range(1) * 8'hFF) : 8'($urandom);
		m.sender  = (pool > 0) ? $urandom_range(pool - 1) : $urandom;
		m.on_chan = 1'($urandom_range(1));
		m.chan    = (pool > 0) ? ($urandom_range(1) ? 32'hFFFF_FFFF : 0) : $urandom;
		m.kind    = (pool > 0) ? 2'($urandom_range(2)) : 2'($urandom_range(3));
		if ($urandom_range(9) == 0) m.kind = 2'd3;
		// time mostly creeps forward, sometimes jumps or goes back
		case ($urandom_range(9))
			0: clock_s = $urandom;
			1: clock_s = clock_s - $urandom_range(3);
			2, 3, 4: ;
			default: clock_s = clock_s + $urandom_range(2);
		endcase
		m.now = clock_s;
		return m;
	endfunction

	row_t directed[$];
	initial begin
		msg_t m;
		int phase;
		errors = 0; words_in = 0; words_out = 0; floods = 0; cycles = 0;
		send_idle_pct = 0; recv_stall_pct = 0; clock_s = 32'h1000;
		s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
		m_axis_tready = 0; cfg_we = 0; cfg_addr = '0; cfg_wdata = '0;
		arst_n = 0;
		trk = 3; after_th = 3; rate_th = 3;
		clear_slots();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed rows: unknown server, first taken slots, repeats, extremes
		directed = '{
			'{'{1'b0, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF},
				1'b1, '{OUT_NOT_CHECKED, 4'd0, 32'd0}},
			'{'{1'b1, 8'h00, 32'h0, 1'b0, 32'h0, 2'd0, 32'd10},
				1'b1, '{OUT_NO_FLOOD, 4'd1, 32'd1}},
			'{'{1'b1, 8'h00, 32'h0, 1'b0, 32'h0, 2'd0, 32'd10}, 1'b0, '0},
			'{'{1'b1, 8'h00, 32'h0, 1'b0, 32'h0, 2'd0, 32'd10}, 1'b0, '0},
			'{'{1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 2'd1, 32'hFFFF_FFFF},
				1'b1, '{OUT_NO_FLOOD, 4'd2, 32'd1}},
			'{'{1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 2'd1, 32'd0}, 1'b0, '0},
			'{'{1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 2'd1, 32'd0}, 1'b0, '0},
			'{'{1'b1, 8'h12, 32'h5, 1'b1, 32'h0, 2'd2, 32'd50}, 1'b0, '0},
			'{'{1'b1, 8'h12, 32'h5, 1'b0, 32'h0, 2'd3, 32'd50}, 1'b0, '0},
			'{'{1'b1, 8'h00, 32'h0, 1'b0, 32'h7, 2'd0, 32'd20}, 1'b0, '0},
			'{'{1'b1, 8'h00, 32'h0, 1'b0, 32'h0, 2'd0, 32'd9}, 1'b0, '0}
		};
		foreach (directed[i])
			send_message(directed[i].m, directed[i].check_typed, directed[i].v);
		drain();

		// checking disabled
		write_reg(REG_TRACKED_ENTRIES, 16'd0);
		m = random_message(4);
		m.known = 1;
		send_message(m, 1'b1, '{OUT_DISABLED, 4'd0, 32'd0});
		drain();
		// more than the table holds, lowest thresholds
		write_reg(REG_TRACKED_ENTRIES, 16'd31);
		write_reg(REG_FLOOD_AFTER, 16'd0);
		write_reg(REG_FLOOD_RATE, 16'd0);
		for (int i = 0; i < 6; i++) send_message(random_message(3), 1'b0, '0);
		drain();
		write_reg(REG_FLOOD_AFTER, 16'hFFFF);
		write_reg(REG_FLOOD_RATE, 16'hFFFF);
		for (int i = 0; i < 4; i++) send_message(random_message(2), 1'b0, '0);
		drain();

		// random phases with varied settings and flow control
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			write_reg(REG_TRACKED_ENTRIES, (phase == 5) ? 16'd1 :
				(phase == 6) ? 16'd16 : 16'($urandom_range(2, 16)));
			write_reg(REG_FLOOD_AFTER, (phase == 7) ? 16'd1 : 16'($urandom_range(2, 6)));
			write_reg(REG_FLOOD_RATE, (phase == 3) ? 16'd0 : 16'($urandom_range(1, 4)));
			for (int i = 0; i < 230; i++) begin
				send_message(random_message((i % 10 == 9) ? 0 : $urandom_range(2, 12)),
					1'b0, '0);
				// sender holds off until every result is back
				if (i == 100)
					while (pending_verdicts.size() != 0) @(posedge clk);
			end
			drain();
		end
		send_idle_pct = 0; recv_stall_pct = 0;
		drain();

		$display("covered %0d message words, %0d result words, %0d floods, 8 phases",
			words_in, words_out, floods);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
